FILE: rtl/rotation_vote_line_matcher_macros.svh
// Assertion macros for the rotation vote line matcher.
// Used by modules that take clk and rst as their clock and reset.
`ifndef ROTATION_VOTE_LINE_MATCHER_MACROS_SVH
`define ROTATION_VOTE_LINE_MATCHER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define RVLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvlm assertion failed");

// Next-cycle implication, quiet during reset
`define RVLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvlm assertion failed");

`endif

FILE: rtl/rvlm_pkg.sv
// Shared types, constants and weight tables for the rotation vote line matcher.
// No dependencies.
`default_nettype none
package rvlm_pkg;

  localparam int ANGLE_BINS    = 360;
  localparam int DEF_MAX_LINES = 32;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int HIST_W        = 26;
  localparam int ROM_BITS      = 24;
  localparam int PAIR_CAP      = 32;
  localparam int VOTE_HALF     = 16;
  localparam int PRIOR_LEN     = 42;
  localparam int LINE_IDX_W    = 6;

  typedef enum logic [1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_ADD_A    = 2'd1,
    MODE_ADD_B    = 2'd2,
    MODE_ESTIMATE = 2'd3
  } mode_t;

  localparam logic CFG_PRIOR_MEAN   = 1'b0;
  localparam logic CFG_MATCH_WINDOW = 1'b1;

  // Scan memory read addresses driven by the engine
  typedef struct packed {
    logic [LINE_IDX_W-1:0] a_addr;
    logic [LINE_IDX_W-1:0] b_addr;
  } scan_rd_t;

  // Round-half-up reduction of a 24-bit table value to wbits, saturated
  function automatic logic [ROM_BITS:0] reduce_weight(input logic [ROM_BITS-1:0] v,
                                                      input int wbits);
    logic [ROM_BITS:0] r;
    logic [ROM_BITS:0] lim;
    int s;
    s = ROM_BITS - wbits;
    r = {1'b0, v};
    if (s > 0) r = (r + (25'd1 << (s - 1))) >> s;
    lim = (25'd1 << wbits) - 25'd1;
    return (r > lim) ? lim : r;
  endfunction

  function automatic logic [ROM_BITS-1:0] vote_rom(input logic [4:0] d);
    case (d)
      5'd0:  return 24'd16777215;
      5'd1:  return 24'd15760735;
      5'd2:  return 24'd13066108;
      5'd3:  return 24'd9559369;
      5'd4:  return 24'd6171993;
      5'd5:  return 24'd3516695;
      5'd6:  return 24'd1768305;
      5'd7:  return 24'd784682;
      5'd8:  return 24'd307285;
      5'd9:  return 24'd106195;
      5'd10: return 24'd32388;
      5'd11: return 24'd8717;
      5'd12: return 24'd2070;
      5'd13: return 24'd434;
      5'd14: return 24'd80;
      5'd15: return 24'd13;
      5'd16: return 24'd2;
      default: return 24'd0;
    endcase
  endfunction

  function automatic logic [ROM_BITS-1:0] prior_rom(input logic [8:0] d);
    case (d)
      9'd0:  return 24'd16777215;
      9'd1:  return 24'd16610279;
      9'd2:  return 24'd16119371;
      9'd3:  return 24'd15333221;
      9'd4:  return 24'd14296599;
      9'd5:  return 24'd13066108;
      9'd6:  return 24'd11705066;
      9'd7:  return 24'd10278164;
      9'd8:  return 24'd8846498;
      9'd9:  return 24'd7463479;
      9'd10: return 24'd6171993;
      9'd11: return 24'd5002920;
      9'd12: return 24'd3974988;
      9'd13: return 24'd3095724;
      9'd14: return 24'd2363212;
      9'd15: return 24'd1768305;
      9'd16: return 24'd1296958;
      9'd17: return 24'd932414;
      9'd18: return 24'd657061;
      9'd19: return 24'd453855;
      9'd20: return 24'd307285;
      9'd21: return 24'd203930;
      9'd22: return 24'd132658;
      9'd23: return 24'd84587;
      9'd24: return 24'd52867;
      9'd25: return 24'd32388;
      9'd26: return 24'd19449;
      9'd27: return 24'd11448;
      9'd28: return 24'd6605;
      9'd29: return 24'd3735;
      9'd30: return 24'd2070;
      9'd31: return 24'd1125;
      9'd32: return 24'd599;
      9'd33: return 24'd313;
      9'd34: return 24'd160;
      9'd35: return 24'd80;
      9'd36: return 24'd39;
      9'd37: return 24'd19;
      9'd38: return 24'd9;
      9'd39: return 24'd4;
      9'd40: return 24'd2;
      9'd41: return 24'd1;
      default: return 24'd0;
    endcase
  endfunction

  // Circular distance between two bins in 0..359
  function automatic logic [8:0] circ_dist(input logic [8:0] x, input logic [8:0] y);
    logic [8:0] d;
    d = (x >= y) ? (x - y) : (y - x);
    return (d > 9'd180) ? (9'd360 - d) : d;
  endfunction

  // (b - a) mod 360 for bins in 0..359
  function automatic logic [8:0] angle_diff(input logic [8:0] b, input logic [8:0] a);
    logic [9:0] s;
    s = {1'b0, b} + 10'd360 - {1'b0, a};
    if (s >= 10'd360) s = s - 10'd360;
    return s[8:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rvlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rvlm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/rvlm_scan_store.sv
// Scan A and scan B angle memories with their fill counts.
// Depends on rvlm_pkg and rvlm_ram.
`default_nettype none
module rvlm_scan_store #(
  parameter int MAX_LINES = rvlm_pkg::DEF_MAX_LINES,
  localparam int CW = $clog2(MAX_LINES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire logic              load_a,
  input  wire logic              load_b,
  input  wire logic [8:0]        angle,
  input  wire rvlm_pkg::scan_rd_t rd,
  output logic      [8:0]        a_data,
  output logic      [8:0]        b_data,
  output logic      [CW-1:0]     count_a,
  output logic      [CW-1:0]     count_b
);
  import rvlm_pkg::*;

  localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  logic [8:0] angle_mod;
  logic       we_a;
  logic       we_b;

  // Reduce the loaded angle into 0..359
  assign angle_mod = (angle >= 9'(ANGLE_BINS)) ? (angle - 9'(ANGLE_BINS)) : angle;

  // Drop loads past capacity
  assign we_a = load_a && (count_a < CW'(MAX_LINES));
  assign we_b = load_b && (count_b < CW'(MAX_LINES));

  // Advance or clear the fill counts
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count_a <= '0;
      count_b <= '0;
    end else begin
      if (we_a) count_a <= count_a + CW'(1);
      if (we_b) count_b <= count_b + CW'(1);
    end
  end

  rvlm_ram #(.WIDTH(9), .DEPTH(MAX_LINES)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[LW-1:0]),
    .wdata (angle_mod),
    .raddr (rd.a_addr[LW-1:0]),
    .rdata (a_data)
  );

  rvlm_ram #(.WIDTH(9), .DEPTH(MAX_LINES)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[LW-1:0]),
    .wdata (angle_mod),
    .raddr (rd.b_addr[LW-1:0]),
    .rdata (b_data)
  );

endmodule
`default_nettype wire

FILE: rtl/rvlm_engine.sv
// Estimate sequencer: histogram clear, vote accumulation, prior argmax, matching.
// Depends on rvlm_pkg, rvlm_ram and the assertion macro header.
`default_nettype none
`include "rotation_vote_line_matcher_macros.svh"
module rvlm_engine #(
  parameter int MAX_LINES   = rvlm_pkg::DEF_MAX_LINES,
  parameter int WEIGHT_BITS = rvlm_pkg::DEF_WEIGHT_BITS,
  localparam int CW = $clog2(MAX_LINES + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               est_start,
  input  wire logic [8:0]         prior_mean,
  input  wire logic [7:0]         match_window,
  input  wire logic [CW-1:0]      count_a,
  input  wire logic [CW-1:0]      count_b,
  input  wire logic [8:0]         a_data,
  input  wire logic [8:0]         b_data,
  output rvlm_pkg::scan_rd_t      rd,
  output logic                    busy,
  output logic                    result_strobe,
  output logic                    is_pair,
  output logic      [4:0]         line_b_index,
  output logic      [4:0]         line_a_index,
  output logic      [8:0]         rotation_deg,
  output logic                    rotation_found,
  output logic                    last
);
  import rvlm_pkg::*;

  localparam int PW = HIST_W + WEIGHT_BITS;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_CLEAR   = 11'b00000000010,
    S_PAIR_RD = 11'b00000000100,
    S_PAIR_T  = 11'b00000001000,
    S_VOTE_RD = 11'b00000010000,
    S_VOTE_WR = 11'b00000100000,
    S_PRI_RD  = 11'b00001000000,
    S_PRI_MUL = 11'b00010000000,
    S_PRI_CMP = 11'b00100000000,
    S_MATCH   = 11'b01000000000,
    S_SUM     = 11'b10000000000
  } state_t;

  state_t state;
  logic [CW-1:0]      i;
  logic [CW-1:0]      j;
  logic [5:0]         off;
  logic [8:0]         t;
  logic [8:0]         bin;
  logic [8:0]         k;
  logic [5:0]         n;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      best;
  logic [8:0]         rot;
  logic               found;
  // Matching alternates an address cycle and a test cycle
  logic               match_phase;

  logic [8:0]         mean;
  logic [9:0]         bin_x;
  logic [9:0]         bin_y;
  logic [8:0]         bin_calc;
  logic [4:0]         vote_d;
  logic [WEIGHT_BITS-1:0] vote_w;
  logic [8:0]         prior_d;
  logic [WEIGHT_BITS-1:0] prior_w;
  logic [HIST_W:0]    vote_sum;
  logic [8:0]         match_t;
  logic               hit;
  logic               a_more;
  logic               b_more;

  logic               h_we;
  logic [8:0]         h_waddr;
  logic [HIST_W-1:0]  h_wdata;
  logic [8:0]         h_raddr;
  logic [HIST_W-1:0]  h_rdata;

  // Prior center reduced into 0..359
  assign mean = (prior_mean >= 9'(ANGLE_BINS)) ? (prior_mean - 9'(ANGLE_BINS)) : prior_mean;

  // Histogram bin for the current vote offset, wrapped
  assign bin_x    = {1'b0, t} + {4'd0, off};
  assign bin_y    = (bin_x >= 10'(VOTE_HALF)) ? (bin_x - 10'(VOTE_HALF))
                                              : (bin_x + 10'(ANGLE_BINS - VOTE_HALF));
  assign bin_calc = (bin_y >= 10'(ANGLE_BINS)) ? 9'(bin_y - 10'(ANGLE_BINS)) : bin_y[8:0];

  // Vote and prior weights from the tables
  assign vote_d   = (off >= 6'(VOTE_HALF)) ? 5'(off - 6'(VOTE_HALF)) : 5'(6'(VOTE_HALF) - off);
  assign vote_w   = WEIGHT_BITS'(reduce_weight(vote_rom(vote_d), WEIGHT_BITS));
  assign prior_d  = circ_dist(k, mean);
  assign prior_w  = (prior_d < 9'(PRIOR_LEN))
                    ? WEIGHT_BITS'(reduce_weight(prior_rom(prior_d), WEIGHT_BITS)) : '0;

  // Saturating bin update
  assign vote_sum = {1'b0, h_rdata} + (HIST_W + 1)'(vote_w);

  // Pair test for matching
  assign match_t = angle_diff(b_data, a_data);
  assign hit     = circ_dist(match_t, rot) < {1'b0, match_window};
  assign a_more  = (j + CW'(1)) < count_a;
  assign b_more  = (i + CW'(1)) < count_b;

  assign rd.a_addr = LINE_IDX_W'(j);
  assign rd.b_addr = LINE_IDX_W'(i);
  assign busy      = (state != S_IDLE);

  // Histogram port selection
  always_comb begin
    h_we    = 1'b0;
    h_waddr = bin;
    h_wdata = '0;
    h_raddr = k;
    case (state)
      S_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = k;
      end
      S_VOTE_RD: h_raddr = bin_calc;
      S_VOTE_WR: begin
        h_we    = 1'b1;
        h_wdata = vote_sum[HIST_W] ? {HIST_W{1'b1}} : vote_sum[HIST_W-1:0];
      end
      default: ;
    endcase
  end

  rvlm_ram #(.WIDTH(HIST_W), .DEPTH(ANGLE_BINS)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      i <= '0;
      j <= '0;
      k <= '0;
      n <= '0;
      rot         <= '0;
      found       <= 1'b0;
      match_phase <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (est_start) begin
            k     <= '0;
            best  <= '0;
            rot   <= '0;
            found <= 1'b0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          i <= '0;
          j <= '0;
          if (k == 9'(ANGLE_BINS - 1)) begin
            k <= '0;
            if (count_a == '0 || count_b == '0) state <= S_PRI_RD;
            else state <= S_PAIR_RD;
          end else begin
            k <= k + 9'd1;
          end
        end
        S_PAIR_RD: state <= S_PAIR_T;
        S_PAIR_T: begin
          t     <= angle_diff(b_data, a_data);
          off   <= '0;
          state <= S_VOTE_RD;
        end
        S_VOTE_RD: begin
          bin   <= bin_calc;
          state <= S_VOTE_WR;
        end
        S_VOTE_WR: begin
          if (off == 6'(2 * VOTE_HALF)) begin
            if (a_more) begin
              j     <= j + CW'(1);
              state <= S_PAIR_RD;
            end else if (b_more) begin
              j     <= '0;
              i     <= i + CW'(1);
              state <= S_PAIR_RD;
            end else begin
              k     <= '0;
              state <= S_PRI_RD;
            end
          end else begin
            off   <= off + 6'd1;
            state <= S_VOTE_RD;
          end
        end
        S_PRI_RD: state <= S_PRI_MUL;
        S_PRI_MUL: begin
          prod  <= PW'(h_rdata) * PW'(prior_w);
          state <= S_PRI_CMP;
        end
        S_PRI_CMP: begin
          if (prod > best) begin
            best  <= prod;
            rot   <= k;
            found <= 1'b1;
          end
          if (k == 9'(ANGLE_BINS - 1)) begin
            i           <= '0;
            j           <= '0;
            n           <= '0;
            match_phase <= 1'b0;
            if (count_a == '0 || count_b == '0) state <= S_SUM;
            else state <= S_MATCH;
          end else begin
            k     <= k + 9'd1;
            state <= S_PRI_RD;
          end
        end
        S_MATCH: begin
          if (match_phase) begin
            if (hit) begin
              result_strobe  <= 1'b1;
              is_pair        <= 1'b1;
              line_b_index   <= 5'(i);
              line_a_index   <= 5'(j);
              rotation_deg   <= rot;
              rotation_found <= found;
              last           <= 1'b0;
              n              <= n + 6'd1;
              j              <= '0;
              if (b_more && (n + 6'd1) < 6'(PAIR_CAP)) i <= i + CW'(1);
              else state <= S_SUM;
            end else if (a_more) begin
              j <= j + CW'(1);
            end else begin
              j <= '0;
              if (b_more) i <= i + CW'(1);
              else state <= S_SUM;
            end
          end
          match_phase <= ~match_phase;
        end
        S_SUM: begin
          result_strobe  <= 1'b1;
          is_pair        <= 1'b0;
          line_b_index   <= '0;
          line_a_index   <= '0;
          rotation_deg   <= rot;
          rotation_found <= found;
          last           <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RVLM_ASSERT_NOW(a_hist_we_src, h_we, (state == S_CLEAR) || (state == S_VOTE_WR))
  `RVLM_ASSERT_NOW(a_pair_cap, 1'b1, n <= 6'(PAIR_CAP))
  `RVLM_ASSERT_NOW(a_pair_not_last, result_strobe && is_pair, !last)
  `RVLM_ASSERT_NEXT(a_est_busy, est_start && !busy, busy)
  `RVLM_ASSERT_NOW(a_found_rot, !found, rot == 9'd0)

endmodule
`default_nettype wire

FILE: rtl/rotation_vote_line_matcher.sv
// Rotation vote line matcher top: command port, configuration registers,
// scan store, estimate engine. Depends on rvlm_pkg, rvlm_scan_store and rvlm_engine.
//
// Load items (clear, add A line, add B line) leave busy low.
// An estimate item raises busy and walks: a histogram clearing pass; when both
// scans hold lines, the 33-bin vote read-modify-write on the histogram memory
// for each (B line, A line) pair; the prior-weighted argmax (read, multiply,
// compare per bin); when both scans hold lines, matching of pairs; ending
// with the summary. Results appear one cycle each on result_strobe and cannot be
// stalled; the summary (last high) is the final one, and busy falls in that
// same cycle.
`default_nettype none
module rotation_vote_line_matcher #(
  parameter int MAX_LINES   = rvlm_pkg::DEF_MAX_LINES,
  parameter int WEIGHT_BITS = rvlm_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode,
  input  wire logic [8:0] angle_index,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data,
  output logic            result_strobe,
  output logic            is_pair,
  output logic [4:0]      line_b_index,
  output logic [4:0]      line_a_index,
  output logic [8:0]      rotation_deg,
  output logic            rotation_found,
  output logic            last
);
  import rvlm_pkg::*;

  localparam int CW = $clog2(MAX_LINES + 1);

  logic [8:0]    prior_mean;
  logic [7:0]    match_window;
  logic          take;
  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic [8:0]    a_data;
  logic [8:0]    b_data;
  scan_rd_t      rd;

  assign take      = start && !busy;
  assign cfg_ready = !busy && !start;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_mean   <= 9'd0;
      match_window <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRIOR_MEAN:   prior_mean   <= cfg_data;
        CFG_MATCH_WINDOW: match_window <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rvlm_scan_store #(.MAX_LINES(MAX_LINES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (take && mode == MODE_CLEAR),
    .load_a  (take && mode == MODE_ADD_A),
    .load_b  (take && mode == MODE_ADD_B),
    .angle   (angle_index),
    .rd      (rd),
    .a_data  (a_data),
    .b_data  (b_data),
    .count_a (count_a),
    .count_b (count_b)
  );

  rvlm_engine #(.MAX_LINES(MAX_LINES), .WEIGHT_BITS(WEIGHT_BITS)) u_engine (
    .clk            (clk),
    .rst            (rst),
    .est_start      (take && mode == MODE_ESTIMATE),
    .prior_mean     (prior_mean),
    .match_window   (match_window),
    .count_a        (count_a),
    .count_b        (count_b),
    .a_data         (a_data),
    .b_data         (b_data),
    .rd             (rd),
    .busy           (busy),
    .result_strobe  (result_strobe),
    .is_pair        (is_pair),
    .line_b_index   (line_b_index),
    .line_a_index   (line_a_index),
    .rotation_deg   (rotation_deg),
    .rotation_found (rotation_found),
    .last           (last)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_rotation_vote_line_matcher.sv
// Testbench for the rotation vote line matcher: directed table then random scan scenes,
// every result checked against expectations queued in this file, most by a line-matching
// predictor. Depends on rvlm_pkg and rotation_vote_line_matcher.
`default_nettype none
module tb_rotation_vote_line_matcher;
  import rvlm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 300000;
  localparam int LINES = 32;
  localparam int RAND_ITEMS = 355;

  typedef struct packed {
    logic       is_pair;
    logic [4:0] b_idx;
    logic [4:0] a_idx;
    logic [8:0] rot;
    logic       found;
    logic       last;
  } match_t;

  typedef struct {
    mode_t m;
    int    ang;
    bit    typed;
  } row_t;

  // Gaussian tables, 24-bit values by circular distance
  localparam int unsigned VOTE_TAB [17] = '{
    16777215, 15760735, 13066108, 9559369, 6171993, 3516695, 1768305, 784682,
    307285, 106195, 32388, 8717, 2070, 434, 80, 13, 2};
  localparam int unsigned PRIOR_TAB [42] = '{
    16777215, 16610279, 16119371, 15333221, 14296599, 13066108, 11705066,
    10278164, 8846498, 7463479, 6171993, 5002920, 3974988, 3095724, 2363212,
    1768305, 1296958, 932414, 657061, 453855, 307285, 203930, 132658, 84587,
    52867, 32388, 19449, 11448, 6605, 3735, 2070, 1125, 599, 313, 160, 80,
    39, 19, 9, 4, 2, 1};

  logic       clk, rst, start, busy, cfg_valid, cfg_ready, cfg_index;
  logic [1:0] mode;
  logic [8:0] angle_index, cfg_data;
  logic       result_strobe, is_pair, rotation_found, last;
  logic [4:0] line_b_index, line_a_index;
  logic [8:0] rotation_deg;

  rotation_vote_line_matcher dut (
    .clk, .rst, .start, .busy, .mode, .angle_index,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .result_strobe, .is_pair, .line_b_index, .line_a_index,
    .rotation_deg, .rotation_found, .last
  );

  // Predictor state
  int      a_ang [LINES];
  int      b_ang [LINES];
  int      a_cnt, b_cnt;
  int      prior_mean, window;
  match_t  pending_q [$];
  int      errors, idle_pct, items_sent;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned shrink(int unsigned v);
    longint unsigned r;
    r = (longint'(v) + 128) >> 8;
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic int arc(int x, int y);
    int d;
    d = (x >= y) ? x - y : y - x;
    return (d > 180) ? 360 - d : d;
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void queue_result(match_t r);
    pending_q = {pending_q, r};
  endfunction

  // Run the vote, prior weighting and matching; queue the expected matches and summary
  task automatic predict_estimate();
    longint unsigned hist [360];
    longint unsigned best, p, v, w;
    int rot, mean, t, d, n;
    bit found;
    best = 0; rot = 0; found = 0; n = 0;
    foreach (hist[k]) hist[k] = 0;
    for (int i = 0; i < b_cnt; i++)
      for (int j = 0; j < a_cnt; j++) begin
        t = (b_ang[i] + 360 - a_ang[j]) % 360;
        for (int k = 0; k < 360; k++) begin
          d = arc(k, t);
          v = (d < 17) ? shrink(VOTE_TAB[d]) : 0;
          hist[k] = hist[k] + v;
          if (hist[k] > 64'd67108863) hist[k] = 64'd67108863;
        end
      end
    mean = prior_mean % 360;
    for (int k = 0; k < 360; k++) begin
      d = arc(k, mean);
      w = (d < 42) ? shrink(PRIOR_TAB[d]) : 0;
      p = hist[k] * w;
      if (p > best) begin
        best = p; rot = k; found = 1;
      end
    end
    for (int i = 0; i < b_cnt && n < 32; i++)
      for (int j = 0; j < a_cnt; j++) begin
        t = (b_ang[i] + 360 - a_ang[j]) % 360;
        if (arc(t, rot) < window) begin
          queue_result('{1'b1, i[4:0], j[4:0], rot[8:0], found, 1'b0});
          n++;
          break;
        end
      end
    queue_result('{1'b0, 5'd0, 5'd0, rot[8:0], found, 1'b1});
  endtask

  task automatic apply_item(mode_t m, logic [8:0] ang);
    case (m)
      MODE_CLEAR: begin
        a_cnt = 0; b_cnt = 0;
      end
      MODE_ADD_A: if (a_cnt < LINES) begin
        a_ang[a_cnt] = ang % 360; a_cnt++;
      end
      MODE_ADD_B: if (b_cnt < LINES) begin
        b_ang[b_cnt] = ang % 360; b_cnt++;
      end
      default: predict_estimate();
    endcase
  endtask

  // Drive one command and hold it until the transfer; typed rows bypass the predictor
  task automatic send_cmd(mode_t m, logic [8:0] ang, bit typed = 0);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    mode = m;
    angle_index = ang;
    do @(posedge clk); while (busy);
    if (typed) queue_result('{1'b0, 5'd0, 5'd0, 9'd0, 1'b0, 1'b1});
    else apply_item(m, ang);
    items_sent++;
  endtask

  // Hold the sender until every expected result is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PRIOR_MEAN) prior_mean = val;
    else window = val[7:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One scene: clear, load A, load B mostly rotated from A with jitter, estimate
  task automatic run_scene();
    int na, nb, rot, base;
    bit wide;
    wide = ($urandom_range(24) == 0);
    na = wide ? $urandom_range(30, 34) : $urandom_range(0, 5);
    nb = wide ? $urandom_range(30, 34) : $urandom_range(0, 5);
    rot = $urandom_range(359);
    send_cmd(MODE_CLEAR, 9'($urandom_range(511)));
    repeat (na) send_cmd(MODE_ADD_A, 9'($urandom_range(511)));
    repeat (nb) begin
      if (a_cnt == 0 || $urandom_range(7) == 0) base = $urandom_range(511);
      else base = (a_ang[$urandom_range(a_cnt - 1)] + rot + 360 +
                   $urandom_range(6) - 3) % 360;
      send_cmd(MODE_ADD_B, 9'(base));
    end
    send_cmd(MODE_ESTIMATE, 9'($urandom_range(511)));
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    match_t got, want;
    if (!rst && result_strobe) begin
      got = '{is_pair, line_b_index, line_a_index, rotation_deg, rotation_found, last};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_q[0];
        pending_q.delete(0);
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    row_t plan [17];
    int   pm [8];
    int   wn [8];
    rst = 1'b1; start = 1'b0; mode = MODE_CLEAR; angle_index = '0;
    cfg_valid = 1'b0; cfg_index = CFG_PRIOR_MEAN; cfg_data = '0;
    a_cnt = 0; b_cnt = 0; prior_mean = 0; window = 10;
    errors = 0; idle_pct = 0; items_sent = 0; quiet_cycles = 0;
    plan = '{
      '{MODE_ESTIMATE, 0, 1},   // empty scans
      '{MODE_ADD_A, 0, 0},
      '{MODE_ESTIMATE, 511, 1}, // A only, no B lines
      '{MODE_ADD_B, 511, 0},    // reduced to 151
      '{MODE_ADD_B, 0, 0},
      '{MODE_ADD_A, 359, 0},
      '{MODE_ESTIMATE, 0, 0},
      '{MODE_ADD_A, 256, 0},
      '{MODE_ADD_B, 255, 0},
      '{MODE_ESTIMATE, 0, 0},
      '{MODE_CLEAR, 0, 0},
      '{MODE_ADD_B, 100, 0},
      '{MODE_ESTIMATE, 0, 1},   // B only, no A lines
      '{MODE_CLEAR, 511, 0},
      '{MODE_ADD_A, 360, 0},
      '{MODE_ADD_B, 359, 0},
      '{MODE_ESTIMATE, 0, 0}
    };
    pm = '{511, 0, 359, $urandom_range(359), 180, $urandom_range(511), 1, 0};
    wn = '{0, 180, 255, 10, 1, $urandom_range(511), $urandom_range(30), 20};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[r]) send_cmd(plan[r].m, 9'(plan[r].ang), plan[r].typed);

    // Random phases, each under new register settings, some also under an idle pattern
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_PRIOR_MEAN, 9'(pm[ph]));
      write_reg(CFG_MATCH_WINDOW, 9'(wn[ph]));
      idle_pct = (ph % 4 == 1) ? 73 : (ph % 4 == 3) ? 31 : 0;
      while (items_sent < 17 + (ph + 1) * RAND_ITEMS / 8) begin
        if ($urandom_range(9) == 0)
          send_cmd(mode_t'($urandom_range(3)), 9'($urandom_range(511)));
        else
          run_scene();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: rotation_vote_line_matcher.f
+incdir+rtl
rtl/rvlm_pkg.sv
rtl/rvlm_ram.sv
rtl/rvlm_scan_store.sv
rtl/rvlm_engine.sv
rtl/rotation_vote_line_matcher.sv
tb/sv/tb_rotation_vote_line_matcher.sv
